FILE: sv/hps_pkg.sv
// shared types, constants and helpers for the humidifier press sequencer
// no dependencies; used by hps_seq, humidifier_press_sequencer and hps_chk
package hps_pkg;

   localparam int COUNT_BITS = 16;
   localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

   localparam int LEVEL_BITS = 10;
   localparam int LEN_BITS   = 16;
   localparam int PHASE_BITS = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int REQ_DATA_BITS  = 16;
   localparam int RSP_DATA_BITS  = 8;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HUMI_ON   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HUMI_OFF  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALARM_HI  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRESS_MS  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REST_MS   = 3'd4;

   // register reset values
   localparam logic [LEVEL_BITS-1:0] HUMI_ON_RST  = 10'd500;
   localparam logic [LEVEL_BITS-1:0] HUMI_OFF_RST = 10'd600;
   localparam logic [LEVEL_BITS-1:0] ALARM_HI_RST = 10'd700;
   localparam logic [LEN_BITS-1:0]   PRESS_RST    = 16'd200;
   localparam logic [LEN_BITS-1:0]   REST_RST     = 16'd1000;

   // item kinds on tuser
   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // sequencer phases
   localparam logic [PHASE_BITS-1:0] PH_IDLE  = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_ONP   = 3'd1;
   localparam logic [PHASE_BITS-1:0] PH_ON    = 3'd2;
   localparam logic [PHASE_BITS-1:0] PH_OFFP1 = 3'd3;
   localparam logic [PHASE_BITS-1:0] PH_REST  = 3'd4;
   localparam logic [PHASE_BITS-1:0] PH_OFFP2 = 3'd5;

   typedef struct packed {
      logic                  drive;
      logic [PHASE_BITS-1:0] phase;
      logic [COUNT_BITS-1:0] count;
   } seq_state_type;

   // length loaded into the countdown, saturated to the counter width
   function automatic logic [COUNT_BITS-1:0] load_len(input logic [LEN_BITS-1:0] len);
      logic [31:0] wide;
      wide = 32'(len);
      if (wide > COUNT_MAX) begin
         return COUNT_MAX[COUNT_BITS-1:0];
      end
      return wide[COUNT_BITS-1:0];
   endfunction

endpackage

FILE: sv/hps_seq.sv
// press sequencer step taken on a tick, after the countdown decrement
// depends on hps_pkg
module hps_seq (
   input  logic                              demand,
   input  logic [hps_pkg::LEN_BITS-1:0]      press_ms,
   input  logic [hps_pkg::LEN_BITS-1:0]      rest_ms,
   input  hps_pkg::seq_state_type            cur,
   output hps_pkg::seq_state_type            nxt
);

   logic zero;

   assign zero = (cur.count == '0);

   always_comb begin
      nxt = cur;
      case (cur.phase)
         hps_pkg::PH_IDLE: begin
            if (demand) begin
               nxt.phase = hps_pkg::PH_ONP;
               nxt.drive = 1'b1;
               nxt.count = hps_pkg::load_len(press_ms);
            end
         end
         hps_pkg::PH_ONP: begin
            if (demand && zero) begin
               nxt.phase = hps_pkg::PH_ON;
               nxt.drive = 1'b0;
            end
         end
         hps_pkg::PH_ON: begin
            if (!demand) begin
               nxt.phase = hps_pkg::PH_OFFP1;
               nxt.drive = 1'b1;
               nxt.count = hps_pkg::load_len(press_ms);
            end
         end
         hps_pkg::PH_OFFP1: begin
            if (!demand && zero) begin
               nxt.phase = hps_pkg::PH_REST;
               nxt.drive = 1'b0;
               nxt.count = hps_pkg::load_len(rest_ms);
            end
         end
         hps_pkg::PH_REST: begin
            if (!demand && zero) begin
               nxt.phase = hps_pkg::PH_OFFP2;
               nxt.drive = 1'b1;
               nxt.count = hps_pkg::load_len(press_ms);
            end
         end
         hps_pkg::PH_OFFP2: begin
            if (!demand && zero) begin
               nxt.phase = hps_pkg::PH_IDLE;
               nxt.drive = 1'b0;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

FILE: sv/humidifier_press_sequencer.sv
// humidifier press sequencer: rsp_tvalid rises in the cycle after a req transfer;
// throughput one item per cycle unless rsp_tready stalls a pending result; state
// and result registers load on the transfer, and the result frees when it is taken.
// synchronous active-high reset: registers to reset values, demand 0, phase idle,
// countdown 0, drive 0, power 1, no result pending. depends on hps_pkg, hps_seq
module humidifier_press_sequencer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [9:0] humidity, [10] sensor_fault, [15:11] zero
   input  logic [hps_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // [0] command
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] press_drive, [1] humidifier_power, [2] demand, [5:3] phase, [7:6] zero
   output logic [hps_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [hps_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [hps_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   logic [hps_pkg::LEVEL_BITS-1:0] humi_on_ff, humi_off_ff, alarm_hi_ff;
   logic [hps_pkg::LEN_BITS-1:0]   press_ff, rest_ff;

   hps_pkg::seq_state_type seq_ff, seq_in, tick_cur, tick_nxt;
   logic demand_ff, demand_in;
   logic power_ff, power_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [hps_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                           req_xfer;
   logic [hps_pkg::LEVEL_BITS-1:0] humidity;
   logic                           fault;
   logic                           dem_clr;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign humidity = req_tdata[hps_pkg::LEVEL_BITS-1:0];
   assign fault    = req_tdata[hps_pkg::LEVEL_BITS];
   assign dem_clr  = demand_ff && !fault;

   // tick path: countdown decrement, then one sequencer step
   always_comb begin
      tick_cur = seq_ff;
      if (seq_ff.count != '0) begin
         tick_cur.count = seq_ff.count - hps_pkg::COUNT_BITS'(1);
      end
   end

   hps_seq u_seq (
      .demand   (demand_ff),
      .press_ms (press_ff),
      .rest_ms  (rest_ff),
      .cur      (tick_cur),
      .nxt      (tick_nxt)
   );

   always_comb begin
      seq_in    = seq_ff;
      demand_in = demand_ff;
      power_in  = power_ff;
      if (req_tuser == hps_pkg::CMD_SAMPLE) begin
         if (!dem_clr) begin
            demand_in = (humidity <= humi_on_ff);
         end else begin
            demand_in = !(humidity >= humi_off_ff);
         end
         if (humidity >= alarm_hi_ff) begin
            power_in     = 1'b0;
            seq_in.phase = hps_pkg::PH_IDLE;
            seq_in.count = '0;
         end else begin
            power_in = 1'b1;
         end
      end else begin
         seq_in = tick_nxt;
      end
      rsp_data_in = {2'b00, seq_in.phase, demand_in, power_in, seq_in.drive};
      rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         humi_on_ff   <= hps_pkg::HUMI_ON_RST;
         humi_off_ff  <= hps_pkg::HUMI_OFF_RST;
         alarm_hi_ff  <= hps_pkg::ALARM_HI_RST;
         press_ff     <= hps_pkg::PRESS_RST;
         rest_ff      <= hps_pkg::REST_RST;
         seq_ff       <= '{drive: 1'b0, phase: hps_pkg::PH_IDLE, count: '0};
         demand_ff    <= 1'b0;
         power_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               hps_pkg::CSR_HUMI_ON:  humi_on_ff  <= csr_data[hps_pkg::LEVEL_BITS-1:0];
               hps_pkg::CSR_HUMI_OFF: humi_off_ff <= csr_data[hps_pkg::LEVEL_BITS-1:0];
               hps_pkg::CSR_ALARM_HI: alarm_hi_ff <= csr_data[hps_pkg::LEVEL_BITS-1:0];
               hps_pkg::CSR_PRESS_MS: press_ff    <= csr_data[hps_pkg::LEN_BITS-1:0];
               hps_pkg::CSR_REST_MS:  rest_ff     <= csr_data[hps_pkg::LEN_BITS-1:0];
               default: begin
               end
            endcase
         end
         if (req_xfer) begin
            seq_ff    <= seq_in;
            demand_ff <= demand_in;
            power_ff  <= power_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

FILE: sv/hps_chk.sv
// port-level checks for humidifier_press_sequencer, attached by bind
// depends on hps_pkg
module hps_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [hps_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);

   logic [hps_pkg::PHASE_BITS-1:0] phase;
   logic                           drive;

   assign phase = rsp_tdata[5:3];
   assign drive = rsp_tdata[0];

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // every transfer in gives a result next cycle
   a_req_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("no result after input transfer");

   // press phases show the drive high
   a_press_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (phase == hps_pkg::PH_ONP || phase == hps_pkg::PH_OFFP1 ||
                     phase == hps_pkg::PH_OFFP2) |-> drive)
      else $error("drive low in a press phase");

   // steady and rest phases show the drive low
   a_rest_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (phase == hps_pkg::PH_ON || phase == hps_pkg::PH_REST) |-> !drive)
      else $error("drive high outside a press");

   // nothing pending right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind humidifier_press_sequencer hps_chk u_hps_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
